[design/assert_macros.svh]
// assertion macros shared by the lexer rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// condition must never be true at a clock edge out of reset
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

[design/scll_pkg.sv]
// shared types, codes and constants of the command line lexer
package scll_pkg;

    localparam int MAX_RES    = 4;
    localparam int N_W        = $clog2(MAX_RES + 1);
    localparam int IDX_W      = $clog2(MAX_RES);
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int FD_W       = 31;
    localparam int CNT16_W    = 16;

    localparam logic [FD_W-1:0] FD_MAX = 31'h7FFF_FFFF;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    typedef enum logic [2:0] {
        M_IDLE, M_UNQ, M_QUO, M_ESC, M_HEX, M_LT, M_GT, M_GTGT
    } mode_t;

    typedef enum logic [2:0] {
        EV_TEXT, EV_ARG_END, EV_FILE_END, EV_REDIRECT,
        EV_PROC_END, EV_LINE_END, EV_EMPTY_LINE, EV_ERROR
    } event_t;

    typedef enum logic [2:0] {
        ERR_BAD_HEX, ERR_EOL_QUOTE, ERR_BAD_ESC, ERR_LTLT,
        ERR_GTGTGT, ERR_NO_TARGET, ERR_NO_PROC
    } err_t;

    typedef enum logic [1:0] {
        RK_TRUNC, RK_APPEND, RK_READ
    } kind_t;

    typedef struct packed {
        mode_t              mode;
        logic [3:0]         hex_value;
        logic               hex_seen;
        logic [FD_W-1:0]    fd_accum;
        logic               fd_overflow;
        logic               all_digits;
        logic               redir_pending;
        logic [CNT16_W-1:0] arg_cnt;
        logic [CNT16_W-1:0] redir_cnt;
        logic               has_proc;
        logic               skip;
    } state_t;

    localparam state_t ST_RESET = '{
        mode: M_IDLE, hex_value: 4'd0, hex_seen: 1'b0, fd_accum: '0,
        fd_overflow: 1'b0, all_digits: 1'b1, redir_pending: 1'b0,
        arg_cnt: '0, redir_cnt: '0, has_proc: 1'b0, skip: 1'b0
    };

    typedef struct packed {
        event_t             evt;
        logic [7:0]         text;
        logic               discard;
        kind_t              kind;
        logic [FD_W-1:0]    fd;
        logic [CNT16_W-1:0] arg_cnt;
        logic [CNT16_W-1:0] redir_cnt;
        err_t               err;
        logic               last;
    } res_t;

    typedef res_t [MAX_RES-1:0] res_arr_t;

endpackage

[design/scll_step.sv]
// lexer step: one byte and the line state in, results and next state out
module scll_step import scll_pkg::*; (
    input  state_t         st,
    input  logic [7:0]     ch,
    output state_t         st_next,
    output res_arr_t       res,
    output logic [N_W-1:0] n_res
);

    typedef struct packed {
        state_t         st;
        res_arr_t       res;
        logic [N_W-1:0] n;
    } ctx_t;

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_NL) || (c == CH_NUL);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_VT) ||
               (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // valid bit above the nibble value
    function automatic logic [4:0] hex_nib(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (is_digit(c)) begin
            r = {1'b1, c[3:0]};
        end else if (((c >= CH_UP_A) && (c <= CH_UP_F)) ||
                     ((c >= CH_LO_A) && (c <= CH_LO_F))) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic res_t mk(input event_t ev);
        res_t r;
        r = '0;
        r.evt = ev;
        return r;
    endfunction

    function automatic ctx_t emit(input ctx_t xi, input res_t r);
        ctx_t x;
        x = xi;
        if (x.n < N_W'(MAX_RES)) begin
            x.res[x.n[IDX_W-1:0]] = r;
            x.n = x.n + N_W'(1);
        end
        return x;
    endfunction

    function automatic ctx_t emit_text(input ctx_t xi, input logic [7:0] b);
        res_t r;
        r = mk(EV_TEXT);
        r.text = b;
        return emit(xi, r);
    endfunction

    function automatic ctx_t clear_line(input ctx_t xi);
        ctx_t x;
        x = xi;
        x.st.mode          = M_IDLE;
        x.st.hex_value     = '0;
        x.st.hex_seen      = 1'b0;
        x.st.fd_accum      = '0;
        x.st.fd_overflow   = 1'b0;
        x.st.all_digits    = 1'b1;
        x.st.redir_pending = 1'b0;
        x.st.arg_cnt       = '0;
        x.st.redir_cnt     = '0;
        x.st.has_proc      = 1'b0;
        return x;
    endfunction

    function automatic ctx_t fail(input ctx_t xi, input err_t code, input logic [7:0] c);
        ctx_t x;
        res_t r;
        r = mk(EV_ERROR);
        r.err = code;
        x = emit(xi, r);
        x = clear_line(x);
        x.st.skip = !is_term(c);
        return x;
    endfunction

    function automatic ctx_t text_end(input ctx_t xi);
        ctx_t x;
        x = xi;
        x.st.mode        = M_IDLE;
        x.st.fd_accum    = '0;
        x.st.fd_overflow = 1'b0;
        x.st.all_digits  = 1'b1;
        if (x.st.redir_pending) begin
            x = emit(x, mk(EV_FILE_END));
            if (x.st.redir_cnt != '1) x.st.redir_cnt = x.st.redir_cnt + 1'b1;
            x.st.redir_pending = 1'b0;
        end else begin
            x = emit(x, mk(EV_ARG_END));
            if (x.st.arg_cnt != '1) x.st.arg_cnt = x.st.arg_cnt + 1'b1;
        end
        return x;
    endfunction

    function automatic ctx_t close_proc(input ctx_t xi, input logic [7:0] c, input logic eol);
        ctx_t x;
        res_t r;
        x = xi;
        if (x.st.redir_pending) begin
            x = fail(x, ERR_NO_TARGET, c);
        end else if (x.st.arg_cnt == '0) begin
            if (eol && !x.st.has_proc && (x.st.redir_cnt == '0)) begin
                x = emit(x, mk(EV_EMPTY_LINE));
                x = clear_line(x);
            end else begin
                x = fail(x, ERR_NO_PROC, c);
            end
        end else begin
            r = mk(EV_PROC_END);
            r.arg_cnt   = x.st.arg_cnt;
            r.redir_cnt = x.st.redir_cnt;
            x = emit(x, r);
            x.st.arg_cnt   = '0;
            x.st.redir_cnt = '0;
            x.st.has_proc  = 1'b1;
            if (eol) begin
                x = emit(x, mk(EV_LINE_END));
                x = clear_line(x);
            end
        end
        return x;
    endfunction

    function automatic ctx_t idle_char(input ctx_t xi, input logic [7:0] c);
        ctx_t x;
        x = xi;
        x.st.mode = M_IDLE;
        if (is_term(c)) begin
            x = close_proc(x, c, 1'b1);
        end else if (is_blank(c)) begin
            x.st.mode = M_IDLE;
        end else if (c == CH_PIPE) begin
            x = close_proc(x, c, 1'b0);
        end else if (c == CH_QUOTE) begin
            x.st.mode = M_QUO;
        end else if (c == CH_LT) begin
            x.st.mode       = M_LT;
            x.st.fd_accum   = '0;
            x.st.all_digits = 1'b0;
        end else if (c == CH_GT) begin
            x.st.mode       = M_GT;
            x.st.fd_accum   = FD_W'(1);
            x.st.all_digits = 1'b0;
        end else begin
            x.st.mode        = M_UNQ;
            x.st.fd_overflow = 1'b0;
            x.st.all_digits  = is_digit(c);
            x.st.fd_accum    = is_digit(c) ? FD_W'(c[3:0]) : '0;
            x = emit_text(x, c);
        end
        return x;
    endfunction

    function automatic ctx_t redirect(input ctx_t xi, input kind_t kind, input logic [7:0] c);
        ctx_t x;
        res_t r;
        x = xi;
        if (x.st.redir_pending) begin
            x = fail(x, ERR_NO_TARGET, c);
        end else begin
            r = mk(EV_REDIRECT);
            r.discard = x.st.all_digits;
            r.kind    = kind;
            r.fd      = x.st.fd_accum;
            x = emit(x, r);
            x.st.redir_pending = 1'b1;
            x.st.fd_accum      = '0;
            x.st.all_digits    = 1'b1;
            x.st.fd_overflow   = 1'b0;
            x = idle_char(x, c);
        end
        return x;
    endfunction

    function automatic ctx_t unq_char(input ctx_t xi, input logic [7:0] c);
        ctx_t x;
        logic [FD_W+3:0] acc;
        x = xi;
        acc = {x.st.fd_accum, 3'b000} + {2'b00, x.st.fd_accum, 1'b0} + (FD_W+4)'(c[3:0]);
        if ((c == CH_LT) || (c == CH_GT)) begin
            if (x.st.all_digits && !x.st.fd_overflow) begin
                x.st.mode       = (c == CH_LT) ? M_LT : M_GT;
                x.st.all_digits = 1'b1;
            end else begin
                x = text_end(x);
                x = idle_char(x, c);
            end
        end else if (is_term(c) || is_blank(c) || (c == CH_PIPE)) begin
            x = text_end(x);
            x = idle_char(x, c);
        end else begin
            x = emit_text(x, c);
            if (!is_digit(c)) begin
                x.st.all_digits = 1'b0;
            end else if (x.st.all_digits && !x.st.fd_overflow) begin
                if (acc > (FD_W+4)'(FD_MAX)) x.st.fd_overflow = 1'b1;
                else x.st.fd_accum = acc[FD_W-1:0];
            end
        end
        return x;
    endfunction

    ctx_t       x;
    logic [4:0] nib;

    always_comb begin
        x     = '0;
        x.st  = st;
        nib   = hex_nib(ch);
        if (st.skip) begin
            if (is_term(ch)) x.st.skip = 1'b0;
        end else begin
            unique case (st.mode)
                M_UNQ: begin
                    x = unq_char(x, ch);
                end
                M_QUO: begin
                    if (ch == CH_QUOTE) x = text_end(x);
                    else if (is_term(ch)) x = fail(x, ERR_EOL_QUOTE, ch);
                    else if (ch == CH_BSLASH) x.st.mode = M_ESC;
                    else x = emit_text(x, ch);
                end
                M_ESC: begin
                    if (ch == CH_LO_N) begin
                        x = emit_text(x, CH_NL);
                        x.st.mode = M_QUO;
                    end else if (ch == CH_BSLASH) begin
                        x = emit_text(x, CH_BSLASH);
                        x.st.mode = M_QUO;
                    end else if (ch == CH_LO_X) begin
                        x.st.hex_value = '0;
                        x.st.hex_seen  = 1'b0;
                        x.st.mode      = M_HEX;
                    end else begin
                        x = fail(x, ERR_BAD_ESC, ch);
                    end
                end
                M_HEX: begin
                    if (!nib[4]) begin
                        x = fail(x, ERR_BAD_HEX, ch);
                    end else if (!st.hex_seen) begin
                        x.st.hex_value = nib[3:0];
                        x.st.hex_seen  = 1'b1;
                    end else begin
                        x = emit_text(x, {st.hex_value, nib[3:0]});
                        x.st.hex_value = '0;
                        x.st.hex_seen  = 1'b0;
                        x.st.mode      = M_QUO;
                    end
                end
                M_LT: begin
                    if (ch == CH_LT) x = fail(x, ERR_LTLT, ch);
                    else x = redirect(x, RK_READ, ch);
                end
                M_GT: begin
                    if (ch == CH_GT) x.st.mode = M_GTGT;
                    else x = redirect(x, RK_TRUNC, ch);
                end
                M_GTGT: begin
                    if (ch == CH_GT) x = fail(x, ERR_GTGTGT, ch);
                    else x = redirect(x, RK_APPEND, ch);
                end
                default: begin
                    x = idle_char(x, ch);
                end
            endcase
        end
        for (int i = 0; i < MAX_RES; i++) begin
            x.res[i].last = (N_W'(i + 1) == x.n);
        end
    end

    assign st_next = x.st;
    assign res     = x.res;
    assign n_res   = x.n;

endmodule

[design/scll_fifo.sv]
// result queue: takes up to four results per cycle, hands out one per cycle while pop is high
`include "assert_macros.svh"
module scll_fifo import scll_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [N_W-1:0]   push_n,
    input  res_arr_t         push_data,
    input  logic             pop,
    output res_t             head,
    output logic             head_valid,
    output logic [CNT_W-1:0] count
);

    res_t             mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop_ok;

    assign pop_ok      = pop && (count_reg != '0);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop_ok);
    assign count_next  = count_reg + CNT_W'(push_n) - CNT_W'(pop_ok);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RES; i++) begin
            if (N_W'(i) < push_n) mem_reg[wr_ptr_reg + PTR_W'(i)] <= push_data[i];
        end
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign count      = count_reg;

    `ASSERT_NEVER(a_fifo_overflow, (32'(count_reg) + 32'(push_n)) > 32'(FIFO_DEPTH), "queue overflow")
    `ASSERT_AT_CLK(a_fifo_ptrs, PTR_W'(count_reg) == PTR_W'(wr_ptr_reg - rd_ptr_reg), "pointer mismatch")
    `ASSERT_NEVER(a_fifo_count, count_reg > CNT_W'(FIFO_DEPTH), "count beyond depth")

endmodule

[design/shell_command_line_lexer_core.sv]
// top level of the shell command line lexer: input register, lexer step, result queue
// an accepted byte is held in the input register, then its results are queued for m_
// throughput: one byte per cycle while m_tready is high and bytes give at most one result
// a byte with k results puts k entries on m_, one per transfer; the 8-entry result queue
// stops input when it could not take four more results
// reset: aresetn synchronous active low, clears lexer state and empties the queue
`include "assert_macros.svh"
module shell_command_line_lexer_core import scll_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [7:0] text_byte, [8] discard_text, [10:9] redirect_kind,
                                   // [41:11] target_fd, [57:42] arg_count,
                                   // [73:58] redirect_count, [76:74] error_code
    output logic [2:0]  m_tuser,   // [2:0] event_res
    output logic        m_tlast
);

    localparam int SUM_W = CNT_W + 1;

    logic             in_valid_reg, in_valid_next;
    logic [7:0]       in_ch_reg;
    state_t           st_reg, st_next;
    res_arr_t         step_res;
    logic [N_W-1:0]   step_n;
    logic [N_W-1:0]   push_n;
    res_t             head;
    logic [CNT_W-1:0] q_count;

    assign push_n        = in_valid_reg ? step_n : '0;
    assign s_tready      = (SUM_W'(q_count) + SUM_W'(push_n)) <= SUM_W'(FIFO_DEPTH - MAX_RES);
    assign in_valid_next = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= ST_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (in_valid_reg) st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_next) in_ch_reg <= s_tdata;
    end

    scll_step u_step (
        .st      (st_reg),
        .ch      (in_ch_reg),
        .st_next (st_next),
        .res     (step_res),
        .n_res   (step_n)
    );

    scll_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_n     (push_n),
        .push_data  (step_res),
        .pop        (m_tready),
        .head       (head),
        .head_valid (m_tvalid),
        .count      (q_count)
    );

    assign m_tdata = {3'b000, head.err, head.redir_cnt, head.arg_cnt, head.fd,
                      head.kind, head.discard, head.text};
    assign m_tuser = head.evt;
    assign m_tlast = head.last;

    `ASSERT_AT_CLK(a_skip_silent, (in_valid_reg && st_reg.skip) |-> (step_n == '0), "output while skipping")
    `ASSERT_AT_CLK(a_skip_needs_err, (in_valid_reg && !st_reg.skip && st_next.skip) |-> (step_n != '0), "skip without error")
    `ASSERT_AT_CLK(a_idle_hold, !in_valid_reg |=> (st_reg == $past(st_reg)), "state moved without item")

endmodule
